>>> src/efsa_pkg.sv
// Shared constants and codes for the earliest-free server assignment block.
package efsa_pkg;

  // Field widths fixed by the stream format
  localparam int unsigned TimeW  = 17;  // remaining time and service period
  localparam int unsigned CfgW   = 4;   // active server count register
  localparam int unsigned SrvW   = 3;   // server index fields
  localparam int unsigned ModeW  = 1;

  // Packed stream widths (tdata padded to whole bytes)
  localparam int unsigned InDataW  = ((SrvW + TimeW + 7) / 8) * 8;
  localparam int unsigned OutDataW = ((SrvW + 7) / 8) * 8;

  // Default number of servers
  localparam int unsigned DefMaxServers = 8;

  // Reset values
  localparam logic [CfgW-1:0]  ActiveReset = CfgW'(8);
  localparam logic [TimeW-1:0] PeriodReset = TimeW'(1);

  // Transaction kinds carried on tuser
  typedef enum logic [ModeW-1:0] {
    MODE_LOAD   = 1'b0,
    MODE_ARRIVE = 1'b1
  } mode_e;

endpackage

>>> src/efsa_argmin.sv
// Registered-free minimum tree: picks the valid entry with the smallest time, lowest index on ties.
module efsa_argmin #(
  parameter int unsigned NumServers = efsa_pkg::DefMaxServers,
  parameter int unsigned IdxW       = 3
) (
  input  logic [efsa_pkg::TimeW-1:0] times_i [NumServers],
  input  logic [NumServers-1:0]      cand_i,
  output logic [IdxW-1:0]            min_idx_o,
  output logic [efsa_pkg::TimeW-1:0] min_time_o
);
  import efsa_pkg::*;

  localparam int unsigned LvlW   = $clog2(NumServers);
  localparam int unsigned Leaves = 1 << LvlW;
  localparam int unsigned Nodes  = 2 * Leaves - 1;

  typedef struct packed {
    logic             vld;
    logic [IdxW-1:0]  idx;
    logic [TimeW-1:0] t;
  } node_t;

  node_t node [Nodes];

  // Leaves in heap order; padding leaves never win
  for (genvar j = 0; j < Leaves; j++) begin : g_leaf
    if (j < NumServers) begin : g_used
      assign node[Leaves-1+j] = '{vld: cand_i[j], idx: IdxW'(j), t: times_i[j]};
    end else begin : g_pad
      assign node[Leaves-1+j] = '0;
    end
  end

  // Internal nodes: left subtree holds lower indices, so it wins ties
  for (genvar k = 0; k < Leaves - 1; k++) begin : g_node
    assign node[k] = (node[2*k+2].vld &&
                      (!node[2*k+1].vld || (node[2*k+2].t < node[2*k+1].t)))
                     ? node[2*k+2] : node[2*k+1];
  end

  assign min_idx_o  = node[0].idx;
  assign min_time_o = node[0].t;

endmodule

>>> src/earliest_free_server_assign.sv
// Top level of the earliest-free server assignment block.
//
// Input stream (s_axis): tuser carries the transaction kind. A load transaction
// writes one server's service period and clears every remaining time; it gives
// no result. An arrival transaction picks the active server that frees first
// (lowest index on ties), ages all servers by that time, restarts the chosen
// server with its period and returns its index on the output stream (m_axis).
// Configuration: cfg_we_i writes the active server count (0 acts as 1, values
// above MaxServers act as MaxServers); write it only while the block is idle.
// Result: registered; it appears in the cycle after its arrival transaction is accepted.
// Throughput: one transaction per clock unless stalled; the path from the state
// registers through the minimum tree and the parallel subtract back to the state sets it.
// Reset: remaining times clear to zero, periods go to one, count goes to 8.
// Stall: the result register holds while m_axis_tready is low; new input is
// taken in the same cycle the held result leaves.
module earliest_free_server_assign #(
  parameter int unsigned MaxServers = efsa_pkg::DefMaxServers
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [efsa_pkg::CfgW-1:0]     cfg_wdata_i,   // active_servers
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [efsa_pkg::InDataW-1:0]  s_axis_tdata,  // [2:0] server_index, [19:3] period
  input  logic [efsa_pkg::ModeW-1:0]    s_axis_tuser,  // [0] mode
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [efsa_pkg::OutDataW-1:0] m_axis_tdata   // [2:0] server
);
  import efsa_pkg::*;

  localparam int unsigned IdxW  = (MaxServers > 1) ? $clog2(MaxServers) : 1;
  localparam int unsigned CntW  = $clog2(MaxServers + 1);
  localparam int unsigned CmpW  = (CntW > CfgW) ? CntW : CfgW;

  logic [CfgW-1:0]  active_q;
  logic [TimeW-1:0] rem_q    [MaxServers];
  logic [TimeW-1:0] rem_d    [MaxServers];
  logic [TimeW-1:0] period_q [MaxServers];
  logic [TimeW-1:0] period_d [MaxServers];
  logic             out_vld_q, out_vld_d;
  logic [SrvW-1:0]  out_srv_q, out_srv_d;

  logic              in_acc;
  mode_e             in_mode;
  logic [SrvW-1:0]   in_idx;
  logic [TimeW-1:0]  in_period;
  logic [CmpW-1:0]   act_cnt;
  logic [MaxServers-1:0] cand;
  logic [IdxW-1:0]   best_idx;
  logic [TimeW-1:0]  best_time;

  // Unpack the input transaction
  assign in_mode   = mode_e'(s_axis_tuser);
  assign in_idx    = s_axis_tdata[SrvW-1:0];
  assign in_period = s_axis_tdata[SrvW+TimeW-1:SrvW];

  assign s_axis_tready = !out_vld_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Effective active count, clamped to 1..MaxServers
  always_comb begin
    act_cnt = CmpW'(active_q);
    if (act_cnt == '0) begin
      act_cnt = CmpW'(1);
    end else if (act_cnt > CmpW'(MaxServers)) begin
      act_cnt = CmpW'(MaxServers);
    end
  end

  for (genvar i = 0; i < MaxServers; i++) begin : g_cand
    assign cand[i] = (CmpW'(i) < act_cnt);
  end

  efsa_argmin #(
    .NumServers (MaxServers),
    .IdxW       (IdxW)
  ) u_argmin (
    .times_i    (rem_q),
    .cand_i     (cand),
    .min_idx_o  (best_idx),
    .min_time_o (best_time)
  );

  // Next state of times, periods and result register
  always_comb begin
    rem_d     = rem_q;
    period_d  = period_q;
    out_srv_d = out_srv_q;
    out_vld_d = out_vld_q && !m_axis_tready;
    if (in_acc) begin
      case (in_mode)
        MODE_LOAD: begin
          for (int i = 0; i < MaxServers; i++) begin
            rem_d[i] = '0;
            if (CmpW'(in_idx) == CmpW'(i)) begin
              period_d[i] = in_period;
            end
          end
        end
        MODE_ARRIVE: begin
          for (int i = 0; i < MaxServers; i++) begin
            rem_d[i] = (rem_q[i] > best_time) ? (rem_q[i] - best_time) : '0;
            if (best_idx == IdxW'(i)) begin
              rem_d[i] = period_q[i];
            end
          end
          out_vld_d = 1'b1;
          out_srv_d = SrvW'(best_idx);
        end
        default: begin
          rem_d = rem_q;
        end
      endcase
    end
  end

  // State and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= ActiveReset;
      out_vld_q <= 1'b0;
      out_srv_q <= '0;
      for (int i = 0; i < MaxServers; i++) begin
        rem_q[i]    <= '0;
        period_q[i] <= PeriodReset;
      end
    end else begin
      if (cfg_we_i) begin
        active_q <= cfg_wdata_i;
      end
      out_vld_q <= out_vld_d;
      out_srv_q <= out_srv_d;
      rem_q     <= rem_d;
      period_q  <= period_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OutDataW'(out_srv_q);

  // Assertions
  a_result_from_arrival: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(in_acc && (in_mode == MODE_ARRIVE)))
    else $error("result raised without an arrival");

  a_best_is_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_mode == MODE_ARRIVE)) |-> (CmpW'(best_idx) < act_cnt))
    else $error("chosen server is not active");

  a_load_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_mode == MODE_LOAD)) |=> (rem_q[0] == '0))
    else $error("load did not clear remaining times");

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_mode == MODE_LOAD) && !out_vld_q) |=> !out_vld_q)
    else $error("load produced a result");

endmodule
